// ===== src/dxtea_pkg.sv =====
// Shared constants, types and the XTEA mixing function for the double XTEA cipher.
package dxtea_pkg;

  // XTEA round constant and key layout
  localparam logic [31:0] Delta       = 32'h9E3779B9;
  localparam int          KeyWords    = 8;
  localparam int          KeyIdxW     = 4;   // index port, wide enough to see out-of-range writes
  localparam int          CyclesDflt  = 64;

  // Command codes
  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // Control bundle from the sequencer output decode to the datapath
  typedef struct packed {
    logic load;     // take a new block
    logic step;     // run one half-round
    logic pass_end; // last half-round of a pass
    logic finish;   // last half-round of the second pass
  } ctrl_t;

  // XTEA mixing function: ((v << 4) ^ (v >> 5)) + v
  function automatic logic [31:0] mix(input logic [31:0] v);
    mix = ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

// ===== src/double_xtea_block_cipher.sv =====
// Double XTEA block cipher: key registers, half-round sequencer and shared round unit.
// One block runs from the start beat to the done strobe as two XTEA passes, and the
// single shared round unit does one half-round (one word update) per clock while it
// runs. busy_o is high while the passes run, and start_i is ignored meanwhile.
// The result is shown on
// out_low_o/out_high_o/key_present_o for exactly one clock with done_o high; the
// receiver cannot stall it, and a new start may be given in that same clock. Key words
// are written through cfg_we_i/cfg_idx_i/cfg_data_i; indexes above 7 are ignored.
module double_xtea_block_cipher #(
  parameter int CYCLES = dxtea_pkg::CyclesDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cmd_i,
  input  logic [31:0]                   block_low_i,
  input  logic [31:0]                   block_high_i,
  // result channel
  output logic                          done_o,
  output logic [31:0]                   out_low_o,
  output logic [31:0]                   out_high_o,
  output logic                          key_present_o,
  // key write port
  input  logic                          cfg_we_i,
  input  logic [dxtea_pkg::KeyIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_data_i
);
  import dxtea_pkg::*;

  localparam int          CntW  = $clog2(CYCLES);
  localparam logic [31:0] SInit = 32'(64'(Delta) * 64'(CYCLES));

  state_e            state_q, state_d;
  ctrl_t             ctrl;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              half_q, half_d;
  logic              pass_q, pass_d;
  logic              dec_q, dec_d;
  logic [31:0]       x_q, x_d, y_q, y_d, s_q, s_d;
  logic [31:0]       key_q [KeyWords];
  logic              done_q;
  logic [31:0]       out_low_q, out_high_q;
  logic              key_present_q;

  logic              last_cnt;
  logic              upd_x;
  logic              bank;
  logic [1:0]        kidx;
  logic [31:0]       key_word;
  logic [31:0]       src_w, acc_w, term, res;
  logic              any_key;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeyWords; i++) key_q[i] <= '0;
    end else if (cfg_we_i && (cfg_idx_i < KeyIdxW'(KeyWords))) begin
      key_q[cfg_idx_i[2:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    any_key = 1'b0;
    for (int i = 0; i < KeyWords; i++) any_key = any_key | (|key_q[i]);
  end

  // Sequencer: next state
  assign last_cnt = (cnt_q == CntW'(CYCLES - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_RUN;
      ST_RUN:  if (half_q && last_cnt && pass_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: output decode
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_IDLE: ctrl.load = start_i;
      ST_RUN: begin
        ctrl.step     = 1'b1;
        ctrl.pass_end = half_q && last_cnt;
        ctrl.finish   = half_q && last_cnt && pass_q;
      end
      default: ctrl = '0;
    endcase
  end

  // Shared round unit: acc +/- (mix(src) ^ (s + k))
  // Encrypt updates x in the first half, decrypt in the second.
  assign upd_x    = (half_q == dec_q);
  assign bank     = pass_q ^ dec_q;
  assign kidx     = upd_x ? s_q[1:0] : s_q[12:11];
  assign key_word = key_q[{bank, kidx}];
  assign src_w    = upd_x ? y_q : x_q;
  assign acc_w    = upd_x ? x_q : y_q;
  assign term     = mix(src_w) ^ (s_q + key_word);
  assign res      = dec_q ? (acc_w - term) : (acc_w + term);

  // Datapath next values
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    s_d    = s_q;
    cnt_d  = cnt_q;
    half_d = half_q;
    pass_d = pass_q;
    dec_d  = dec_q;
    if (ctrl.load) begin
      x_d    = block_low_i;
      y_d    = block_high_i;
      dec_d  = cmd_i;
      s_d    = (cmd_i == CmdDecrypt) ? SInit : '0;
      cnt_d  = '0;
      half_d = 1'b0;
      pass_d = 1'b0;
    end else if (ctrl.step) begin
      if (upd_x) x_d = res;
      else       y_d = res;
      half_d = ~half_q;
      if (!half_q) begin
        s_d = dec_q ? (s_q - Delta) : (s_q + Delta);
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
      // restart the sum for the second pass
      if (ctrl.pass_end) begin
        cnt_d  = '0;
        pass_d = 1'b1;
        s_d    = dec_q ? SInit : '0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      half_q  <= 1'b0;
      pass_q  <= 1'b0;
      dec_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      half_q  <= half_d;
      pass_q  <= pass_d;
      dec_q   <= dec_d;
      done_q  <= ctrl.finish;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    s_q <= s_d;
    if (ctrl.finish) begin
      out_low_q     <= upd_x ? res : x_q;
      out_high_q    <= upd_x ? y_q : res;
      key_present_q <= any_key;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign out_low_o     = out_low_q;
  assign out_high_o    = out_high_q;
  assign key_present_o = key_present_q;

  // Checks
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted start did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("done strobe while still busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe longer than one cycle");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

endmodule
